/* src/mpr_pkg.sv */
// Shared types and constants for the max-plus relaxation block.
`default_nettype none
package mpr_pkg;
    localparam logic [31:0] DEAD_CHILD = 32'hFF80_0000;
    localparam logic [63:0] DBL_ONE    = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN   = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] EXP_MAX    = 11'h7FF;
    localparam logic [10:0] EXP_SCALE  = 11'd50;

    typedef struct packed {
        logic [63:0] act_score;
        logic [63:0] err_floor;
        logic [31:0] child_value;
        logic [63:0] best_cur;
        logic [63:0] err_cur;
        logic        last_of_run;
    } t_in;

    typedef struct packed {
        logic [63:0] best_new;
        logic [63:0] error_new;
        logic        live;
        logic        run_end;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [63:0] best_cur;
        logic [63:0] err_cur;
        logic        live;
        logic        run_end;
    } t_side;

    // IEEE double a < b; false when either is NaN, zeros compare equal
    function automatic logic dbl_less(input logic [63:0] a, input logic [63:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic res;
        a_nan     = (a[62:52] == EXP_MAX) && (a[51:0] != 52'd0);
        b_nan     = (b[62:52] == EXP_MAX) && (b[51:0] != 52'd0);
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (a_nan || b_nan || both_zero) begin
            res = 1'b0;
        end else if (a[63] != b[63]) begin
            res = a[63];
        end else if (!a[63]) begin
            res = a[62:0] < b[62:0];
        end else begin
            res = a[62:0] > b[62:0];
        end
        return res;
    endfunction
endpackage
`default_nettype wire

/* src/mpr_widen.sv */
// Exact single to double precision conversion.
`default_nettype none
module mpr_widen (
    input  wire logic [31:0] i_f,
    output logic      [63:0] o_d
);
    import mpr_pkg::*;

    logic [7:0]  e;
    logic [22:0] f;
    logic [4:0]  lz;
    logic [22:0] fn;
    logic [10:0] en;

    assign e = i_f[30:23];
    assign f = i_f[22:0];

    always_comb begin
        lz = 5'd23;
        for (int i = 0; i < 23; i++) begin
            if (f[i]) lz = 5'(22 - i);
        end
        fn = f << (lz + 5'd1);
        en = 11'(11'd896 - 11'(lz));
        if (e == 8'hFF) begin
            o_d = {i_f[31], EXP_MAX, f, 29'd0};
        end else if (e == 8'd0 && f == 23'd0) begin
            o_d = {i_f[31], 63'd0};
        end else if (e == 8'd0) begin
            o_d = {i_f[31], en, fn, 29'd0};
        end else begin
            o_d = {i_f[31], 11'(11'd896 + 11'(e)), f, 29'd0};
        end
    end
endmodule
`default_nettype wire

/* src/mpr_dadd.sv */
// Five-stage IEEE double adder, round to nearest even.
`default_nettype none
module mpr_dadd (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic      [63:0] o_sum
);
    import mpr_pkg::*;

    logic [63:0] r_spec_val [1:4];
    logic        r_spec     [1:4];
    logic        r_sign     [1:4];
    logic [11:0] r_exp      [1:4];

    logic [55:0] r1_mb;
    logic [55:0] r1_ms;
    logic        r1_sub;
    logic [56:0] r2_sum;
    logic [55:0] r3_m;
    logic [5:0]  r3_sh;
    logic [55:0] r4_m;
    logic [63:0] r5_res;

    logic [63:0] n_spec_val;
    logic        n_spec;
    logic [62:0] big;
    logic [62:0] small_m;
    logic [10:0] eb_e;
    logic [10:0] es_e;
    logic [10:0] d;
    logic [5:0]  dd;
    logic [55:0] ext;
    logic [55:0] shd;
    logic        lost;
    logic        a_inf, b_inf, a_nan, b_nan;
    logic        n_sign1;

    always_comb begin
        a_inf = (i_a[62:52] == EXP_MAX) && (i_a[51:0] == 52'd0);
        b_inf = (i_b[62:52] == EXP_MAX) && (i_b[51:0] == 52'd0);
        a_nan = (i_a[62:52] == EXP_MAX) && (i_a[51:0] != 52'd0);
        b_nan = (i_b[62:52] == EXP_MAX) && (i_b[51:0] != 52'd0);
        n_spec = (i_a[62:52] == EXP_MAX) || (i_b[62:52] == EXP_MAX);
        if (a_nan || b_nan || (a_inf && b_inf && (i_a[63] != i_b[63]))) begin
            n_spec_val = DBL_QNAN;
        end else if (a_inf) begin
            n_spec_val = {i_a[63], EXP_MAX, 52'd0};
        end else begin
            n_spec_val = {i_b[63], EXP_MAX, 52'd0};
        end
        if (i_b[62:0] > i_a[62:0]) begin
            big = i_b[62:0]; small_m = i_a[62:0]; n_sign1 = i_b[63];
        end else begin
            big = i_a[62:0]; small_m = i_b[62:0]; n_sign1 = i_a[63];
        end
        eb_e = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        es_e = (small_m[62:52] == 11'd0) ? 11'd1 : small_m[62:52];
        d    = eb_e - es_e;
        dd   = (d > 11'd63) ? 6'd63 : d[5:0];
        ext  = {(small_m[62:52] != 11'd0), small_m[51:0], 3'd0};
        shd  = ext >> dd;
        lost = |(ext & ~({56{1'b1}} << dd));
    end

    logic [56:0] n_sum;
    logic [5:0]  z;
    logic [55:0] n_m3;
    logic [5:0]  n_sh3;
    logic [11:0] n_exp3;
    logic [11:0] emin;
    logic        n_sign2;

    always_comb begin
        n_sum = r1_sub ? ({1'b0, r1_mb} - {1'b0, r1_ms}) : ({1'b0, r1_mb} + {1'b0, r1_ms});
        n_sign2 = (n_sum == 57'd0) ? (r1_sub ? 1'b0 : r_sign[1]) : r_sign[1];
    end

    always_comb begin
        z = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (r2_sum[i]) z = 6'(55 - i);
        end
        emin = r_exp[2] - 12'd1;
        if (r2_sum == 57'd0) begin
            n_m3   = 56'd0;
            n_sh3  = 6'd0;
            n_exp3 = 12'd0;
        end else if (r2_sum[56]) begin
            n_m3   = {r2_sum[56:2], r2_sum[1] | r2_sum[0]};
            n_sh3  = 6'd0;
            n_exp3 = r_exp[2] + 12'd1;
        end else if (emin < 12'(z)) begin
            n_m3   = r2_sum[55:0];
            n_sh3  = emin[5:0];
            n_exp3 = 12'd0;
        end else begin
            n_m3   = r2_sum[55:0];
            n_sh3  = z;
            n_exp3 = r_exp[2] - 12'(z);
        end
    end

    logic [53:0] mr;
    logic        inc;
    logic [11:0] exp_f;

    always_comb begin
        inc = r4_m[2] & (r4_m[1] | r4_m[0] | r4_m[3]);
        mr  = {1'b0, r4_m[55:3]} + 54'(inc);
        if (mr[53]) begin
            exp_f = r_exp[4] + 12'd1;
        end else if (r_exp[4] == 12'd0 && mr[52]) begin
            exp_f = 12'd1;
        end else begin
            exp_f = r_exp[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec[1]     <= n_spec;
            r_spec_val[1] <= n_spec_val;
            r_sign[1]     <= n_sign1;
            r_exp[1]      <= {1'b0, eb_e};
            r1_mb         <= {(big[62:52] != 11'd0), big[51:0], 3'd0};
            r1_ms         <= {shd[55:1], shd[0] | lost};
            r1_sub        <= i_a[63] ^ i_b[63];

            r_spec[2]     <= r_spec[1];
            r_spec_val[2] <= r_spec_val[1];
            r_sign[2]     <= n_sign2;
            r_exp[2]      <= r_exp[1];
            r2_sum        <= n_sum;

            r_spec[3]     <= r_spec[2];
            r_spec_val[3] <= r_spec_val[2];
            r_sign[3]     <= r_sign[2];
            r_exp[3]      <= n_exp3;
            r3_m          <= n_m3;
            r3_sh         <= n_sh3;

            r_spec[4]     <= r_spec[3];
            r_spec_val[4] <= r_spec_val[3];
            r_sign[4]     <= r_sign[3];
            r_exp[4]      <= r_exp[3];
            r4_m          <= r3_m << r3_sh;

            if (r_spec[4]) begin
                r5_res <= r_spec_val[4];
            end else if (exp_f >= 12'd2047) begin
                r5_res <= {r_sign[4], EXP_MAX, 52'd0};
            end else begin
                r5_res <= {r_sign[4], exp_f[10:0], mr[51:0]};
            end
        end
    end

    assign o_sum = r5_res;
endmodule
`default_nettype wire

/* src/max_plus_relax_with_error_envelope.sv */
// Top level: max-plus relaxation step with error envelope.
// Throughput: one item per cycle while the output is not stalled; input register,
// two chained 5-stage double adders, the error scale register and the output register
// set the depth.
// A stall at the output holds the whole pipeline in place.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module max_plus_relax_with_error_envelope (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mpr_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mpr_pkg::t_out      o_out
);
    import mpr_pkg::*;

    localparam int SIDE_DEPTH = 11;
    localparam int SUM_DELAY  = 6;

    logic        en;
    logic [63:0] child_d;
    logic [63:0] r_partial;
    logic [63:0] r_base;
    logic [63:0] r_child;
    t_side       r_s1_side;
    t_side       r_side [0:SIDE_DEPTH-1];
    logic [63:0] r_cand_dly [0:SUM_DELAY-1];
    logic [63:0] sum_a;
    logic [63:0] sum_b;
    logic [63:0] sum_c;
    logic [10:0] sc_e;
    logic [52:0] sc_m;
    logic [5:0]  sc_sh;
    logic [52:0] sc_q;
    logic [52:0] sc_rem;
    logic [52:0] sc_half;
    logic        sc_up;
    logic [63:0] n_ecand;
    logic [63:0] r_ecand;
    t_side       side_end;
    logic        r_out_valid;
    t_out        r_out;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    mpr_widen u_widen (
        .i_f (i_in.child_value),
        .o_d (child_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side.valid <= 1'b0;
        end else if (en) begin
            r_partial          <= i_in.act_score;
            r_base             <= i_in.err_floor;
            r_child            <= child_d;
            r_s1_side.valid    <= i_in_valid;
            r_s1_side.best_cur <= i_in.best_cur;
            r_s1_side.err_cur  <= i_in.err_cur;
            r_s1_side.live     <= (i_in.child_value != DEAD_CHILD);
            r_s1_side.run_end  <= i_in.last_of_run;
        end
    end

    mpr_dadd u_add_score (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_partial),
        .i_b   (r_child),
        .o_sum (sum_a)
    );

    mpr_dadd u_add_base (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_base),
        .i_b   ({1'b0, r_child[62:0]}),
        .o_sum (sum_b)
    );

    mpr_dadd u_add_one (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (sum_b),
        .i_b   (DBL_ONE),
        .o_sum (sum_c)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIDE_DEPTH; i++) r_side[i].valid <= 1'b0;
        end else if (en) begin
            r_side[0] <= r_s1_side;
            for (int i = 1; i < SIDE_DEPTH; i++) r_side[i] <= r_side[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cand_dly[0] <= sum_a;
            for (int i = 1; i < SUM_DELAY; i++) r_cand_dly[i] <= r_cand_dly[i-1];
        end
    end

    assign side_end = r_side[SIDE_DEPTH-1];

    always_comb begin
        sc_e    = (sum_c[62:52] == 11'd0) ? 11'd1 : sum_c[62:52];
        sc_m    = {(sum_c[62:52] != 11'd0), sum_c[51:0]};
        sc_sh   = EXP_SCALE[5:0] + 6'd1 - sc_e[5:0];
        sc_q    = sc_m >> sc_sh;
        sc_rem  = sc_m & ~({53{1'b1}} << sc_sh);
        sc_half = 53'd1 << (sc_sh - 6'd1);
        sc_up   = (sc_rem > sc_half) || ((sc_rem == sc_half) && sc_q[0]);
        if (sum_c[62:52] == EXP_MAX || sum_c[62:0] == 63'd0) begin
            n_ecand = sum_c;
        end else if (sum_c[62:52] > EXP_SCALE) begin
            n_ecand = {sum_c[63], sum_c[62:52] - EXP_SCALE, sum_c[51:0]};
        end else begin
            n_ecand = {sum_c[63], 10'd0, sc_q + 53'(sc_up)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ecand <= n_ecand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.live    <= side_end.live;
            r_out.run_end <= side_end.run_end;
            if (side_end.live && dbl_less(side_end.best_cur, r_cand_dly[SUM_DELAY-1])) begin
                r_out.best_new <= r_cand_dly[SUM_DELAY-1];
            end else begin
                r_out.best_new <= side_end.best_cur;
            end
            if (side_end.live && dbl_less(side_end.err_cur, r_ecand)) begin
                r_out.error_new <= r_ecand;
            end else begin
                r_out.error_new <= side_end.err_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= side_end.valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
`default_nettype wire
